[design/bld_pkg.sv]
// Shared types, constants and the duty function for the button LED dimmer.
// Used by bld_cfg, bld_core and the top level; depends on nothing.
`default_nettype none

package bld_pkg;

    // Fixed sizes of the level and counters.
    localparam int NUM_LEVELS   = 12;
    localparam int COUNT_WIDTH  = 20;
    localparam int LEVEL_W      = 4;
    localparam int DUTY_W       = 11;
    localparam int AUTO_W       = 19;
    localparam int DIM_W        = 19;
    localparam int WINDOW_W     = 16;
    localparam int CFG_DATA_W   = 19;
    localparam int CFG_INDEX_W  = 2;
    localparam int PRESS_W      = 2;
    localparam int RELEASE_W    = 16;

    // Saturation points of the debounce counters.
    localparam logic [PRESS_W-1:0]   PRESS_SAT   = 2'd2;
    localparam logic [RELEASE_W-1:0] RELEASE_SAT = 16'd65534;

    // Top level and full-scale duty.
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(NUM_LEVELS - 1);
    localparam logic [DUTY_W-1:0]  DUTY_FULL = 11'd1024;

    // Register reset values.
    localparam logic [AUTO_W-1:0]   AUTO_OFF_RESET = 19'd112260;
    localparam logic [DIM_W-1:0]    DIM_RESET      = 19'd9355;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 16'd40;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AUTO_OFF = 2'd0,
        CFG_DIM      = 2'd1,
        CFG_WINDOW   = 2'd2
    } t_cfg_idx;

    // Settings as the tick logic sees them; the off limit is auto-off plus dim.
    typedef struct packed {
        logic [AUTO_W-1:0]      auto_off;
        logic [WINDOW_W-1:0]    window;
        logic [COUNT_WIDTH-1:0] off_limit;
    } t_cfg;

    // Power-of-two duty for a level, zero at level zero and saturated at full scale.
    function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
        logic [DUTY_W-1:0] d;
        if (lvl == '0) begin
            d = '0;
        end else if (lvl > LEVEL_W'(10)) begin
            d = DUTY_FULL;
        end else begin
            d = DUTY_W'(1) << (lvl - LEVEL_W'(1));
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[design/bld_cfg.sv]
// Configuration registers of the dimmer, with the precomputed off limit.
// Depends on bld_pkg.
`default_nettype none

module bld_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bld_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [bld_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bld_pkg::t_cfg                          o_cfg
);

    logic [bld_pkg::AUTO_W-1:0]      r_auto, n_auto;
    logic [bld_pkg::DIM_W-1:0]       r_dim, n_dim;
    logic [bld_pkg::WINDOW_W-1:0]    r_window, n_window;
    logic [bld_pkg::COUNT_WIDTH-1:0] r_limit, n_limit;

    // Decode a write; an unused index changes nothing.
    always_comb begin
        n_auto   = r_auto;
        n_dim    = r_dim;
        n_window = r_window;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bld_pkg::CFG_AUTO_OFF: n_auto   = i_cfg_data[bld_pkg::AUTO_W-1:0];
                bld_pkg::CFG_DIM:      n_dim    = i_cfg_data[bld_pkg::DIM_W-1:0];
                bld_pkg::CFG_WINDOW:   n_window = i_cfg_data[bld_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
        n_limit = bld_pkg::COUNT_WIDTH'(n_auto) + bld_pkg::COUNT_WIDTH'(n_dim);
    end

    // Register file, loaded with the documented defaults at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto   <= bld_pkg::AUTO_OFF_RESET;
            r_dim    <= bld_pkg::DIM_RESET;
            r_window <= bld_pkg::WINDOW_RESET;
            r_limit  <= bld_pkg::COUNT_WIDTH'(bld_pkg::AUTO_OFF_RESET)
                      + bld_pkg::COUNT_WIDTH'(bld_pkg::DIM_RESET);
        end else begin
            r_auto   <= n_auto;
            r_dim    <= n_dim;
            r_window <= n_window;
            r_limit  <= n_limit;
        end
    end

    assign o_cfg.auto_off  = r_auto;
    assign o_cfg.window    = r_window;
    assign o_cfg.off_limit = r_limit;

endmodule

`default_nettype wire

[design/bld_core.sv]
// Per-tick state update of the dimmer: debounce, level stepping, auto-off.
// Depends on bld_pkg.
`default_nettype none

module bld_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_button_down,
    input  wire bld_pkg::t_cfg                   i_cfg,
    output logic [bld_pkg::DUTY_W-1:0]           o_duty,
    output logic [bld_pkg::LEVEL_W-1:0]          o_level,
    output logic                                 o_leds_on
);

    logic [bld_pkg::LEVEL_W-1:0]     r_level, n_level;
    logic                            r_step_up, n_step_up;
    logic                            r_latched, n_latched;
    logic [bld_pkg::PRESS_W-1:0]     r_press, n_press;
    logic [bld_pkg::RELEASE_W-1:0]   r_release, n_release;
    logic [bld_pkg::COUNT_WIDTH-1:0] r_tick, n_tick;

    logic                            sleep;
    logic [bld_pkg::LEVEL_W-1:0]     shown;
    logic [bld_pkg::LEVEL_W-1:0]     stepped;

    // Next state and the result of one tick.
    always_comb begin
        n_level   = r_level;
        n_step_up = r_step_up;
        n_latched = r_latched;
        n_press   = r_press;
        n_release = r_release;
        n_tick    = r_tick;
        sleep     = 1'b0;
        shown     = '0;
        stepped   = '0;

        // While off, only a fresh press wakes the light at level one.
        if (r_level == '0) begin
            n_tick = '0;
            if (!i_button_down || r_press != '0) begin
                sleep = 1'b1;
                if (!i_button_down) begin
                    n_press = '0;
                end
            end else begin
                n_level = bld_pkg::LEVEL_W'(1);
            end
        end

        if (!sleep) begin
            // Debounce and act on a new press.
            if (!i_button_down) begin
                if (n_release < bld_pkg::RELEASE_SAT) begin
                    n_release = n_release + 1'b1;
                end
                n_press = '0;
                if (n_release > bld_pkg::RELEASE_W'(1)) begin
                    n_latched = 1'b0;
                end
            end else begin
                if (n_press < bld_pkg::PRESS_SAT) begin
                    n_press = n_press + 1'b1;
                end
                if (n_press > bld_pkg::PRESS_W'(1)) begin
                    if (!n_latched) begin
                        if (n_release < i_cfg.window) begin
                            // Ping-pong step through the levels.
                            if (n_step_up) begin
                                stepped = n_level + 1'b1;
                                if (stepped >= bld_pkg::LEVEL_W'(bld_pkg::NUM_LEVELS)
                                    || stepped == '0) begin
                                    n_level   = bld_pkg::LEVEL_TOP;
                                    n_step_up = 1'b0;
                                end else begin
                                    n_level = stepped;
                                end
                            end else begin
                                stepped = n_level - 1'b1;
                                if (stepped == '0
                                    || stepped >= bld_pkg::LEVEL_W'(bld_pkg::NUM_LEVELS)) begin
                                    n_level   = '0;
                                    n_step_up = 1'b1;
                                end else begin
                                    n_level = stepped;
                                end
                            end
                        end else begin
                            n_level = '0;
                        end
                        n_latched = 1'b1;
                    end
                    n_release = '0;
                end
            end

            shown = n_level;

            // Auto-off timer: halve at the first threshold, off past the second.
            n_tick = n_tick + 1'b1;
            if (n_tick == bld_pkg::COUNT_WIDTH'(i_cfg.auto_off)) begin
                n_level = n_level >> 1;
            end
            if (n_tick > i_cfg.off_limit) begin
                n_level = '0;
                n_tick  = '0;
            end
        end
    end

    assign o_level   = shown;
    assign o_duty    = bld_pkg::duty_of(shown);
    assign o_leds_on = (shown != '0);

    // State registers advance once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_step_up <= 1'b1;
            r_latched <= 1'b0;
            r_press   <= '0;
            r_release <= '0;
            r_tick    <= '0;
        end else if (i_en) begin
            r_level   <= n_level;
            r_step_up <= n_step_up;
            r_latched <= n_latched;
            r_press   <= n_press;
            r_release <= n_release;
            r_tick    <= n_tick;
        end
    end

endmodule

`default_nettype wire

[design/button_led_dimmer_with_auto_off.sv]
// Button LED dimmer with auto-off: top level with input and result registers.
// A tick is taken when o_stall is low; its result loads into the result register.
// Throughput: one tick per cycle; the input stage holds while the result stalls.
// Reset (synchronous, active low) clears both stages and loads default settings.
// Depends on bld_pkg, bld_cfg and bld_core.
`default_nettype none

module button_led_dimmer_with_auto_off (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_button_down,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [bld_pkg::DUTY_W-1:0]             o_duty,
    output logic [bld_pkg::LEVEL_W-1:0]            o_level,
    output logic                                   o_leds_on,
    input  wire logic                              i_cfg_we,
    input  wire logic [bld_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [bld_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    bld_pkg::t_cfg                   cfg;
    logic                            r_in_valid;
    logic                            r_in_button;
    logic                            r_out_valid;
    logic [bld_pkg::DUTY_W-1:0]      r_duty;
    logic [bld_pkg::LEVEL_W-1:0]     r_level;
    logic                            r_leds_on;
    logic                            advance;
    logic                            in_xfer;
    logic [bld_pkg::DUTY_W-1:0]      core_duty;
    logic [bld_pkg::LEVEL_W-1:0]     core_level;
    logic                            core_leds_on;

    // The result register can take a new value when empty or being drained.
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    bld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bld_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (r_in_valid && advance),
        .i_button_down (r_in_button),
        .i_cfg         (cfg),
        .o_duty        (core_duty),
        .o_level       (core_level),
        .o_leds_on     (core_leds_on)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_button <= i_button_down;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_duty    <= core_duty;
            r_level   <= core_level;
            r_leds_on <= core_leds_on;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_duty    = r_duty;
    assign o_level   = r_level;
    assign o_leds_on = r_leds_on;

endmodule

`default_nettype wire

[bench/button_led_dimmer_with_auto_off_tb.sv]
// Self-checking testbench for the button LED dimmer with auto-off.
// Predicts duty, level and LED state per tick and checks every result transfer.
// Depends on bld_pkg and button_led_dimmer_with_auto_off.
`timescale 1ns / 1ps

module button_led_dimmer_with_auto_off_tb;

    // Register index that maps to no setting; writes to it must be ignored.
    localparam logic [bld_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    // One expected result: what the LED shows for a tick.
    typedef struct packed {
        logic [bld_pkg::DUTY_W-1:0]  duty;
        logic [bld_pkg::LEVEL_W-1:0] level;
        logic                        leds_on;
    } t_light;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_button_down;
    logic                            o_valid;
    logic                            i_stall;
    logic [bld_pkg::DUTY_W-1:0]      o_duty;
    logic [bld_pkg::LEVEL_W-1:0]     o_level;
    logic                            o_leds_on;
    logic                            i_cfg_we;
    logic [bld_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [bld_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // Lights still owed by the block, oldest first.
    t_light light_q[$];

    // Mirror of the dimmer state and settings.
    logic [bld_pkg::LEVEL_W-1:0]     lvl_m     = '0;
    logic                            rising_m  = 1'b1;
    logic                            latched_m = 1'b0;
    logic [bld_pkg::PRESS_W-1:0]     press_m   = '0;
    logic [bld_pkg::RELEASE_W-1:0]   rel_m     = '0;
    logic [bld_pkg::COUNT_WIDTH-1:0] ticks_m   = '0;
    logic [bld_pkg::AUTO_W-1:0]      auto_m    = bld_pkg::AUTO_OFF_RESET;
    logic [bld_pkg::DIM_W-1:0]       dim_m     = bld_pkg::DIM_RESET;
    logic [bld_pkg::WINDOW_W-1:0]    window_m  = bld_pkg::WINDOW_RESET;

    int n_ticks  = 0;
    int n_lights = 0;
    int n_writes = 0;
    int n_errors = 0;
    bit gaps_on  = 1'b1;

    button_led_dimmer_with_auto_off dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_button_down (i_button_down),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_duty        (o_duty),
        .o_level       (o_level),
        .o_leds_on     (o_leds_on),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock, 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Ping-pong step: up to the top level, then down to off.
    function automatic void step_brightness();
        if (rising_m) begin
            lvl_m = lvl_m + 1'b1;
            if (lvl_m >= bld_pkg::NUM_LEVELS || lvl_m == '0) begin
                lvl_m    = bld_pkg::LEVEL_TOP;
                rising_m = 1'b0;
            end
        end else begin
            lvl_m = lvl_m - 1'b1;
            if (lvl_m == '0 || lvl_m >= bld_pkg::NUM_LEVELS) begin
                lvl_m    = '0;
                rising_m = 1'b1;
            end
        end
    endfunction

    // Advances the mirror by one tick and returns what the LED shows.
    function automatic t_light predict_light(input logic down);
        t_light                        lit;
        logic [bld_pkg::COUNT_WIDTH:0] off_at;
        lit = '0;
        // Asleep: only a fresh press wakes the light at level one.
        if (lvl_m == '0) begin
            ticks_m = '0;
            if (!down || press_m != '0) begin
                if (!down) begin
                    press_m = '0;
                end
                return lit;
            end
            lvl_m = bld_pkg::LEVEL_W'(1);
        end
        // Debounce: two ticks down make a press, two ticks up end it.
        if (!down) begin
            if (rel_m < bld_pkg::RELEASE_SAT) begin
                rel_m++;
            end
            press_m = '0;
            if (rel_m > 1) begin
                latched_m = 1'b0;
            end
        end else begin
            if (press_m < bld_pkg::PRESS_SAT) begin
                press_m++;
            end
            if (press_m > 1) begin
                if (!latched_m) begin
                    if (rel_m < window_m) begin
                        step_brightness();
                    end else begin
                        lvl_m = '0;
                    end
                    latched_m = 1'b1;
                end
                rel_m = '0;
            end
        end
        lit.level = lvl_m;
        if (lvl_m == '0) begin
            lit.duty = '0;
        end else if (lvl_m > bld_pkg::LEVEL_W'(10)) begin
            lit.duty = bld_pkg::DUTY_FULL;
        end else begin
            lit.duty = bld_pkg::DUTY_W'(1) << (lvl_m - 1'b1);
        end
        lit.leds_on = (lit.duty != '0);
        // Auto-off: halve at the first limit, go dark past the second.
        ticks_m = ticks_m + 1'b1;
        if (ticks_m == bld_pkg::COUNT_WIDTH'(auto_m)) begin
            lvl_m = lvl_m >> 1;
        end
        off_at = (bld_pkg::COUNT_WIDTH+1)'(auto_m) + (bld_pkg::COUNT_WIDTH+1)'(dim_m);
        if ({1'b0, ticks_m} > off_at) begin
            lvl_m   = '0;
            ticks_m = '0;
        end
        return lit;
    endfunction

    // Presents one button sample, waits for its transfer and books the result.
    task automatic send_tick(input logic down);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_button_down <= down;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        light_q.push_back(predict_light(down));
        n_ticks++;
        @(negedge i_clk);
    endtask

    // Sends a string of button samples, '1' meaning pressed.
    task automatic send_pattern(input string pat);
        for (int k = 0; k < pat.len(); k++) begin
            send_tick(pat[k] == "1");
        end
    endtask

    // Drains the block, then writes all settings plus the unused index.
    task automatic write_settings(input logic [bld_pkg::AUTO_W-1:0] auto_v,
                                  input logic [bld_pkg::DIM_W-1:0] dim_v,
                                  input logic [bld_pkg::WINDOW_W-1:0] window_v);
        logic [bld_pkg::CFG_DATA_W-bld_pkg::WINDOW_W-1:0] junk;
        junk = (bld_pkg::CFG_DATA_W-bld_pkg::WINDOW_W)'($urandom_range(0, 7));
        i_valid <= 1'b0;
        while (light_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= bld_pkg::CFG_AUTO_OFF;
        i_cfg_data  <= auto_v;
        @(negedge i_clk);
        i_cfg_index <= bld_pkg::CFG_DIM;
        i_cfg_data  <= dim_v;
        @(negedge i_clk);
        // Bits above the window width are ignored by the block.
        i_cfg_index <= bld_pkg::CFG_WINDOW;
        i_cfg_data  <= {junk, window_v};
        @(negedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= bld_pkg::CFG_DATA_W'($urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        auto_m   = auto_v;
        dim_m    = dim_v;
        window_m = window_v;
        n_writes++;
    endtask

    // Sleep ticks, wake and a held press under the reset settings.
    task automatic test_sleep_and_wake();
        send_pattern("0011001100");
    endtask

    // Long release turns the light off; holding on keeps it asleep.
    task automatic test_turn_off_and_hold();
        write_settings(19'h7FFFF, 19'h7FFFF, 16'd1);
        send_pattern("1100011110011");
    endtask

    // Zero window turns off on every press; zero auto-off never halves.
    task automatic test_zero_settings();
        write_settings('0, 19'h7FFFF, '0);
        send_pattern("01100111001100");
    endtask

    // Short limits: halve and go dark while the button is held or stepping.
    task automatic test_auto_off();
        write_settings(19'd1, '0, 16'd40);
        send_pattern("0111110011");
        write_settings(19'd3, 19'd2, 16'd8);
        send_pattern("011001100110000");
    endtask

    // Walks the full ping-pong: up to the top, down through one to off.
    task automatic test_ping_pong();
        write_settings(19'h7FFFF, 19'h7FFFF, 16'hFFFF);
        repeat (26) send_pattern("1100");
    endtask

    // Phases of press sequences with random content under random settings.
    task automatic test_random();
        int stop_at;
        int hold;
        int gap;
        int kind;
        logic [bld_pkg::AUTO_W-1:0]   auto_v;
        logic [bld_pkg::DIM_W-1:0]    dim_v;
        logic [bld_pkg::WINDOW_W-1:0] window_v;
        for (int phase = 0; phase < 8; phase++) begin
            auto_v   = $urandom_range(0, 1) ? bld_pkg::AUTO_W'($urandom_range(1, 60))
                                            : bld_pkg::AUTO_W'($urandom_range(100, 600));
            dim_v    = (phase == 1) ? '0 : bld_pkg::DIM_W'($urandom_range(0, 40));
            window_v = (phase == 2) ? 16'hFFFF : bld_pkg::WINDOW_W'($urandom_range(3, 14));
            if (phase == 0) begin
                auto_v = 19'd1;
            end
            write_settings(auto_v, dim_v, window_v);
            // The last phases run with no gaps on either side.
            gaps_on = (phase < 6);
            stop_at = n_ticks + 100;
            while (n_ticks < stop_at) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6) begin
                    hold = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(2, 3);
                    gap  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                    repeat (hold) send_tick(1'b1);
                    repeat (gap) send_tick(1'b0);
                end else if (kind == 7) begin
                    // A one-tick bounce that must not count as a press.
                    send_tick(1'b1);
                    repeat ($urandom_range(1, 4)) send_tick(1'b0);
                end else begin
                    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Receiver side: stall in random bursts while gaps are enabled.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    // Compares each result transfer with the oldest expected light.
    always @(posedge i_clk) begin : check_lights
        t_light want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_lights++;
            if (light_q.size() == 0) begin
                $display("%0t: result with none expected: duty %0d level %0d leds_on %0b",
                         $time, o_duty, o_level, o_leds_on);
                n_errors++;
            end else begin
                want = light_q.pop_front();
                if (o_duty !== want.duty) begin
                    $display("%0t: duty expected %0d, got %0d", $time, want.duty, o_duty);
                    n_errors++;
                end
                if (o_level !== want.level) begin
                    $display("%0t: level expected %0d, got %0d", $time, want.level, o_level);
                    n_errors++;
                end
                if (o_leds_on !== want.leds_on) begin
                    $display("%0t: leds_on expected %0b, got %0b",
                             $time, want.leds_on, o_leds_on);
                    n_errors++;
                end
            end
        end
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("button_led_dimmer_with_auto_off_tb: done, errors");
        $finish;
    end

    // Reset, then the tests in turn, then the final drain.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_button_down = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = bld_pkg::CFG_AUTO_OFF;
        i_cfg_data    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_sleep_and_wake();
        test_turn_off_and_hold();
        test_zero_settings();
        test_auto_off();
        test_ping_pong();
        test_random();

        i_valid <= 1'b0;
        while (light_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d button ticks, checked %0d results over %0d settings changes.",
                 n_ticks, n_lights, n_writes);
        $display("Covered sleep, wake, stepping both ways, turn-off, auto-dim and auto-off.");
        if (n_errors == 0) begin
            $display("button_led_dimmer_with_auto_off_tb: done, clean");
        end else begin
            $display("button_led_dimmer_with_auto_off_tb: done, errors");
        end
        $finish;
    end

endmodule
